/* src/box_blur_3x3_unit_macros.svh */
// Assertion macros for the checker file of the blur unit.
`ifndef BOX_BLUR_3X3_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bb3_pkg.sv */
package bb3_pkg;

    // Field widths.
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Default line store and frame limits.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [WIDTH_W-1:0]   IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_W-1:0]  IMAGE_HEIGHT_RST = 13'd480;

    // Rounded mean (2*sum+n)/(2*n) is done as a multiply by ceil(2^20/(2*n)).
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;

    function automatic logic [RECIP_W-1:0] bb3_recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd6:    m = 20'd87382;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* src/bb3_pix_if.sv */
interface bb3_pix_if;
    import bb3_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface

/* src/bb3_blur_if.sv */
interface bb3_blur_if;
    import bb3_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     out_red;
    logic [PIX_W-1:0]     out_green;
    logic [PIX_W-1:0]     out_blue;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 run_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_row, output out_col, output run_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_row, input out_col, input run_last, output ready);
endinterface

/* src/box_blur_3x3_unit.sv */
// Streaming 3x3 box blur with edge shrink. Pixels enter in raster order, one item
// per clock unless stalled; each result is the rounded mean of the in-image
// neighbors, released by the item that completes its neighborhood. One line memory
// of MAX_WIDTH entries holds, per column, the two rows above the current one; each
// item reads its column on entry and writes it back as it leaves stage 1, with a
// forward path for the one-pixel-wide case. One result leaves per clock while the
// sink is ready, so the rate is one item per cycle inside the frame; on the last row
// and at the last column an item releases two results (up to four at the frame's
// last pixel) and stalls the input until they are sent. A width or height write
// restarts the frame at row 0, column 0. No clearing pass is needed after reset.
module box_blur_3x3_unit #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bb3_pix_if.sink                        i_pix,
    bb3_blur_if.source                     o_blur
);
    import bb3_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int PX3_W = 3 * PIX_W;
    localparam int COL_W = PIX_W + 2;
    localparam int SUM_W = PIX_W + 4;
    localparam int X_W   = SUM_W + 1;
    localparam int PRD_W = X_W + RECIP_W;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [3:0]            cnt;
        logic [RW-1:0]         row;
        logic [CW-1:0]         col;
    } t_res;

    // Configuration registers.
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                cfg_hit;

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_idx == REG_IMAGE_WIDTH || i_cfg_idx == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= IMAGE_WIDTH_RST;
            r_height <= IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Last column and last row of the frame, with zero read as one and saturation.
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb begin
        if (r_width == '0) begin
            w_last = '0;
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_width - 11'd1);
        end
        if (r_height == '0) begin
            h_last = '0;
        end else if (int'(r_height) > MAX_HEIGHT) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_height - 13'd1);
        end
    end

    // Pipeline flow control.
    logic       r_s1_v;
    logic       r_o_v;
    logic [3:0] r_mask;
    logic [3:0] sel;
    logic [1:0] sel_idx;
    logic [3:0] rem;
    logic       s3_free;
    logic       s2_fire;
    logic       s2_can;
    logic       s1_move;
    logic       in_rdy;
    logic       accept;

    always_comb begin
        if (r_mask[0]) begin
            sel_idx = 2'd0;
        end else if (r_mask[1]) begin
            sel_idx = 2'd1;
        end else if (r_mask[2]) begin
            sel_idx = 2'd2;
        end else begin
            sel_idx = 2'd3;
        end
    end

    assign sel     = 4'b0001 << sel_idx;
    assign rem     = r_mask & ~sel;
    assign s3_free = !r_o_v || o_blur.ready;
    assign s2_fire = (r_mask != '0) && s3_free;
    assign s2_can  = (r_mask == '0) || (s2_fire && rem == '0);
    assign s1_move = r_s1_v && s2_can;
    assign in_rdy  = !r_s1_v || s1_move;
    assign accept  = i_pix.valid && in_rdy;
    assign i_pix.ready = in_rdy;

    // Position of the next incoming pixel.
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_in_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_in_row <= '0;
            r_in_col <= '0;
        end else if (accept) begin
            if (r_in_col == w_last) begin
                r_in_col <= '0;
                r_in_row <= (r_in_row == h_last) ? '0 : r_in_row + 1'b1;
            end else begin
                r_in_col <= r_in_col + 1'b1;
            end
        end
    end

    // Stage 1: item with its column read from the line memory.
    logic [PX3_W-1:0]   r_s1_pix;
    logic [RW-1:0]      r_s1_row;
    logic [CW-1:0]      r_s1_col;
    logic [2*PX3_W-1:0] r_rd;
    logic [2*PX3_W-1:0] r_fwd_data;
    logic               r_fwd;
    logic [2*PX3_W-1:0] rd_eff;
    logic [2*PX3_W-1:0] wr_data;
    logic [2*PX3_W-1:0] mem [MAX_WIDTH];

    assign rd_eff  = r_fwd ? r_fwd_data : r_rd;
    assign wr_data = {r_s1_pix, rd_eff[2*PX3_W-1:PX3_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_rdy) begin
            r_s1_v <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
            r_s1_row   <= r_in_row;
            r_s1_col   <= r_in_col;
            r_fwd      <= s1_move && (r_s1_col == r_in_col);
            r_fwd_data <= wr_data;
        end
    end

    // Line memory: each entry holds {row above, two rows above} of one column.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_in_col];
        end
        if (s1_move) begin
            mem[r_s1_col] <= wr_data;
        end
    end

    // Column sums and the four candidate results of this item.
    logic                  has_r1;
    logic                  has_r2;
    logic                  has_c1;
    logic                  has_c2;
    logic [2:0][COL_W-1:0] col_a;
    logic [2:0][COL_W-1:0] col_b;
    logic [2:0][COL_W-1:0] r_wa1;
    logic [2:0][COL_W-1:0] r_wa2;
    logic [2:0][COL_W-1:0] r_wb1;
    logic [2:0][COL_W-1:0] r_wb2;
    logic [2:0][SUM_W-1:0] sum_a0;
    logic [2:0][SUM_W-1:0] sum_a1;
    logic [2:0][SUM_W-1:0] sum_b0;
    logic [2:0][SUM_W-1:0] sum_b1;
    logic [1:0]            nr_a;
    logic [1:0]            nr_b;
    logic [1:0]            nc_0;
    logic [1:0]            nc_1;
    logic [3:0]            mask_n;
    t_res                  res_n [4];

    assign has_r1 = r_s1_row != '0;
    assign has_r2 = r_s1_row > RW'(1);
    assign has_c1 = r_s1_col != '0;
    assign has_c2 = r_s1_col > CW'(1);

    always_comb begin
        logic [PIX_W-1:0] p0;
        logic [PIX_W-1:0] p1;
        logic [PIX_W-1:0] p2;
        logic [COL_W-1:0] wa1;
        logic [COL_W-1:0] wa2;
        logic [COL_W-1:0] wb1;
        logic [COL_W-1:0] wb2;
        for (int ch = 0; ch < 3; ch++) begin
            p0 = r_s1_pix[PIX_W*(2-ch) +: PIX_W];
            p1 = has_r1 ? rd_eff[PX3_W + PIX_W*(2-ch) +: PIX_W] : '0;
            p2 = has_r2 ? rd_eff[PIX_W*(2-ch) +: PIX_W] : '0;
            col_a[ch] = COL_W'(p0) + COL_W'(p1) + COL_W'(p2);
            col_b[ch] = COL_W'(p0) + COL_W'(p1);
            wa1 = has_c1 ? r_wa1[ch] : '0;
            wa2 = has_c2 ? r_wa2[ch] : '0;
            wb1 = has_c1 ? r_wb1[ch] : '0;
            wb2 = has_c2 ? r_wb2[ch] : '0;
            sum_a1[ch] = SUM_W'(col_a[ch]) + SUM_W'(wa1);
            sum_a0[ch] = sum_a1[ch] + SUM_W'(wa2);
            sum_b1[ch] = SUM_W'(col_b[ch]) + SUM_W'(wb1);
            sum_b0[ch] = sum_b1[ch] + SUM_W'(wb2);
        end
    end

    assign nr_a = 2'd1 + 2'(has_r1) + 2'(has_r2);
    assign nr_b = 2'd1 + 2'(has_r1);
    assign nc_0 = 2'd1 + 2'(has_c1) + 2'(has_c2);
    assign nc_1 = 2'd1 + 2'(has_c1);

    // Results in output order: above-left, above, left, current position.
    always_comb begin
        res_n[0].sum = sum_a0;
        res_n[0].cnt = 4'(nr_a) * 4'(nc_0);
        res_n[0].row = r_s1_row - 1'b1;
        res_n[0].col = r_s1_col - 1'b1;
        res_n[1].sum = sum_a1;
        res_n[1].cnt = 4'(nr_a) * 4'(nc_1);
        res_n[1].row = r_s1_row - 1'b1;
        res_n[1].col = r_s1_col;
        res_n[2].sum = sum_b0;
        res_n[2].cnt = 4'(nr_b) * 4'(nc_0);
        res_n[2].row = r_s1_row;
        res_n[2].col = r_s1_col - 1'b1;
        res_n[3].sum = sum_b1;
        res_n[3].cnt = 4'(nr_b) * 4'(nc_1);
        res_n[3].row = r_s1_row;
        res_n[3].col = r_s1_col;
        mask_n[0] = has_r1 && has_c1;
        mask_n[1] = has_r1 && (r_s1_col == w_last);
        mask_n[2] = (r_s1_row == h_last) && has_c1;
        mask_n[3] = (r_s1_row == h_last) && (r_s1_col == w_last);
    end

    // Column sums of the two previous columns of the same row.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_wa2 <= r_wa1;
            r_wa1 <= col_a;
            r_wb2 <= r_wb1;
            r_wb1 <= col_b;
        end
    end

    // Stage 2: pending results of one item, sent one per cycle while stage 3 is free.
    t_res r_res [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (s1_move) begin
            r_mask <= mask_n;
        end else if (s2_fire) begin
            r_mask <= rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_res <= res_n;
        end
    end

    // Rounded mean by reciprocal multiply.
    t_res                  cur;
    logic [RECIP_W-1:0]    recip;
    logic [2:0][PRD_W-1:0] prod;

    assign cur   = r_res[sel_idx];
    assign recip = bb3_recip(cur.cnt);

    always_comb begin
        logic [X_W-1:0] x;
        for (int ch = 0; ch < 3; ch++) begin
            x = {cur.sum[ch], 1'b0} + X_W'(cur.cnt);
            prod[ch] = PRD_W'(x) * PRD_W'(recip);
        end
    end

    // Stage 3: output register.
    logic [PIX_W-1:0]     r_o_red;
    logic [PIX_W-1:0]     r_o_green;
    logic [PIX_W-1:0]     r_o_blue;
    logic [OUT_ROW_W-1:0] r_o_row;
    logic [OUT_COL_W-1:0] r_o_col;
    logic                 r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s3_free) begin
            r_o_v <= s2_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_o_red   <= prod[0][RECIP_SHIFT +: PIX_W];
            r_o_green <= prod[1][RECIP_SHIFT +: PIX_W];
            r_o_blue  <= prod[2][RECIP_SHIFT +: PIX_W];
            r_o_row   <= OUT_ROW_W'(cur.row);
            r_o_col   <= OUT_COL_W'(cur.col);
            r_o_last  <= rem == '0;
        end
    end

    assign o_blur.valid     = r_o_v;
    assign o_blur.out_red   = r_o_red;
    assign o_blur.out_green = r_o_green;
    assign o_blur.out_blue  = r_o_blue;
    assign o_blur.out_row   = r_o_row;
    assign o_blur.out_col   = r_o_col;
    assign o_blur.run_last  = r_o_last;

endmodule

/* src/bb3_check.sv */
`include "box_blur_3x3_unit_macros.svh"

module bb3_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_last,
    input logic [46:0] i_payload
);
    // Reset empties the output register.
    `BB3_ASSERT_NXT(a_rst_empty, i_clk, 1'b1, !i_rst_n, !i_valid, "output valid after reset")

    // A stalled item holds its value.
    `BB3_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready,
        i_valid && $stable(i_payload), "stalled output item changed")

    // Results of one input leave back to back while the sink takes them.
    `BB3_ASSERT_NXT(a_burst, i_clk, i_rst_n, i_valid && i_ready && !i_last, i_valid,
        "gap inside a run of results")

endmodule

bind box_blur_3x3_unit bb3_check u_bb3_check (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_blur.valid),
    .i_ready   (o_blur.ready),
    .i_last    (o_blur.run_last),
    .i_payload ({o_blur.out_red, o_blur.out_green, o_blur.out_blue,
                 o_blur.out_row, o_blur.out_col, o_blur.run_last})
);

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bb3_pkg::*;

    // Register index past the end of the register list; the block ignores it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
    localparam int STORE_W   = MAX_WIDTH_DEF;
    localparam int STORE_H   = MAX_HEIGHT_DEF;
    localparam int WDOG_MAX  = 4000;
    localparam int LONG_HOLD = 120;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } t_blurred;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bb3_pix_if  pix ();
    bb3_blur_if blur ();

    box_blur_3x3_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix.sink),
        .o_blur     (blur.source)
    );

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: three line stores, frame size and input position.
    logic [23:0]       line_mem [3][STORE_W];
    logic [WIDTH_W-1:0]  frame_w_reg;
    logic [HEIGHT_W-1:0] frame_h_reg;
    int                pos_row;
    int                pos_col;
    int                cur_line;

    t_pixel   pixels_to_send [$];
    t_blurred blurred_expected [$];
    int       error_count;
    int       src_idle_pct;
    int       snk_idle_pct;
    int       hold_req_seq;
    int       hold_seen_seq;
    int       hold_left;
    int       quiet_cycles;

    // Mean over the in-image part of the 3x3 window centered at (y, x).
    function automatic t_blurred blur_window(int y, int x, int cur, int w, int h);
        t_blurred res;
        int sr, sg, sb, cnt, d, buf_idx;
        logic [23:0] p;
        sr = 0;
        sg = 0;
        sb = 0;
        cnt = 0;
        for (int yy = y - 1; yy <= y + 1; yy++) begin
            if (yy < 0 || yy >= h || yy > cur || cur - yy > 2) continue;
            d = cur - yy;
            buf_idx = (cur_line + 3 - d) % 3;
            for (int xx = x - 1; xx <= x + 1; xx++) begin
                if (xx < 0 || xx >= w) continue;
                p = line_mem[buf_idx][xx];
                sr += p[23:16];
                sg += p[15:8];
                sb += p[7:0];
                cnt++;
            end
        end
        if (cnt == 0) cnt = 1;
        res.red   = PIX_W'((2 * sr + cnt) / (2 * cnt));
        res.green = PIX_W'((2 * sg + cnt) / (2 * cnt));
        res.blue  = PIX_W'((2 * sb + cnt) / (2 * cnt));
        res.row   = OUT_ROW_W'(y);
        res.col   = OUT_COL_W'(x);
        res.last  = 1'b0;
        return res;
    endfunction

    // Advances the predictor by one pixel and queues the results it releases.
    task automatic predict_pixel(input t_pixel px);
        int w, h, r, c, n;
        t_blurred found [$];
        w = (frame_w_reg == 0) ? 1 : (frame_w_reg > STORE_W) ? STORE_W : int'(frame_w_reg);
        h = (frame_h_reg == 0) ? 1 : (frame_h_reg > STORE_H) ? STORE_H : int'(frame_h_reg);
        if (pos_col >= w || pos_row >= h) begin
            pos_col = 0;
            pos_row = 0;
            cur_line = 0;
        end
        r = pos_row;
        c = pos_col;
        line_mem[cur_line][c] = px;
        if (r >= 1) begin
            if (c >= 1) found.push_back(blur_window(r - 1, c - 1, r, w, h));
            if (c == w - 1) found.push_back(blur_window(r - 1, c, r, w, h));
        end
        if (r == h - 1) begin
            if (c >= 1) found.push_back(blur_window(r, c - 1, r, w, h));
            if (c == w - 1) found.push_back(blur_window(r, c, r, w, h));
        end
        n = found.size();
        if (n > 0) found[n - 1].last = 1'b1;
        foreach (found[k]) blurred_expected.push_back(found[k]);
        if (c + 1 >= w) begin
            pos_col = 0;
            if (r + 1 >= h) begin
                pos_row = 0;
                cur_line = 0;
            end else begin
                pos_row = r + 1;
                cur_line = (cur_line + 1) % 3;
            end
        end else begin
            pos_col = c + 1;
        end
    endtask

    // Pixel driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid    <= 1'b0;
            pix.in_red   <= '0;
            pix.in_green <= '0;
            pix.in_blue  <= '0;
        end else begin
            if (pix.valid && pix.ready)
                predict_pixel({pix.in_red, pix.in_green, pix.in_blue});
            if (!pix.valid || pix.ready) begin
                if (pixels_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    t_pixel px;
                    px = pixels_to_send.pop_front();
                    pix.valid    <= 1'b1;
                    pix.in_red   <= px.red;
                    pix.in_green <= px.green;
                    pix.in_blue  <= px.blue;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls, including the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blur.ready    <= 1'b0;
            hold_left     <= 0;
            hold_seen_seq <= 0;
        end else begin
            if (blur.valid && blur.ready) begin
                if (blurred_expected.size() == 0) begin
                    $display("%0t: unexpected item row %0d col %0d", $time,
                             blur.out_row, blur.out_col);
                    error_count++;
                end else begin
                    t_blurred exp_item, got;
                    exp_item = blurred_expected.pop_front();
                    got = {blur.out_red, blur.out_green, blur.out_blue,
                           blur.out_row, blur.out_col, blur.run_last};
                    if (got !== exp_item) begin
                        $display("%0t: mismatch expected r%0d g%0d b%0d row%0d col%0d last%0d",
                                 $time, exp_item.red, exp_item.green, exp_item.blue,
                                 exp_item.row, exp_item.col, exp_item.last);
                        $display("%0t:          actual   r%0d g%0d b%0d row%0d col%0d last%0d",
                                 $time, got.red, got.green, got.blue, got.row, got.col,
                                 got.last);
                        error_count++;
                    end
                end
            end
            if (hold_seen_seq != hold_req_seq) begin
                hold_seen_seq <= hold_req_seq;
                hold_left     <= LONG_HOLD;
                blur.ready    <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                blur.ready <= 1'b0;
            end else begin
                blur.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted item while work is outstanding.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix.valid && pix.ready) || (blur.valid && blur.ready) ||
            (pixels_to_send.size() == 0 && !pix.valid && blurred_expected.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Waits until the block has taken every pixel and delivered every result.
    task automatic drain();
        while (pixels_to_send.size() > 0 || pix.valid || blurred_expected.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Register write while the block is idle; mirrored in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
            if (idx == REG_IMAGE_WIDTH) frame_w_reg = WIDTH_W'(value);
            else frame_h_reg = HEIGHT_W'(value);
            pos_row = 0;
            pos_col = 0;
            cur_line = 0;
        end
        @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        case ($urandom_range(9))
            0:       px = '0;
            1:       px = '1;
            default: px = 24'($urandom);
        endcase
        return px;
    endfunction

    task automatic queue_pixels(input int count);
        for (int k = 0; k < count; k++) pixels_to_send.push_back(rand_pixel());
    endtask

    // Random frames of small size; a few are cut short by a restart, others run on into the next frame.
    task automatic random_frames(input int items);
        int sent, w, h, n;
        sent = 0;
        while (sent < items) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            write_reg(REG_IMAGE_WIDTH, w);
            write_reg(REG_IMAGE_HEIGHT, h);
            n = w * h;
            if ($urandom_range(9) == 0) n = $urandom_range(1, n);
            else if ($urandom_range(4) == 0) n = n + $urandom_range(1, w);
            queue_pixels(n);
            sent += n;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        error_count   = 0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        hold_req_seq  = 0;
        quiet_cycles  = 0;
        frame_w_reg   = IMAGE_WIDTH_RST;
        frame_h_reg   = IMAGE_HEIGHT_RST;
        pos_row       = 0;
        pos_col       = 0;
        cur_line      = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset frame size: the first row releases nothing.
        queue_pixels(3);
        // One-pixel frame, channels at both extremes.
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        pixels_to_send.push_back('0);
        pixels_to_send.push_back('1);
        // Zero sizes act as one.
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        pixels_to_send.push_back(24'h80ff01);
        // Full 3x3 frame with corner, edge and center windows.
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        for (int k = 0; k < 9; k++) pixels_to_send.push_back((k % 2) ? '1 : '0);
        // Oversized width saturates; single row releases one result per pixel after the first.
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 1);
        queue_pixels(4);
        // Write to an index past the list must not restart the frame.
        write_reg(REG_UNUSED, 5);
        queue_pixels(2);
        // Oversized height saturates; one column.
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        queue_pixels(4);
        // Top of the width range.
        write_reg(REG_IMAGE_WIDTH, 1024);
        write_reg(REG_IMAGE_HEIGHT, 2);
        queue_pixels(3);

        src_idle_pct = 37;
        snk_idle_pct = 82;
        random_frames(25);
        src_idle_pct = 82;
        snk_idle_pct = 37;
        random_frames(25);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(REG_IMAGE_WIDTH, 6);
        write_reg(REG_IMAGE_HEIGHT, 5);
        hold_req_seq = hold_req_seq + 1;
        queue_pixels(30);
        random_frames(15);

        drain();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
